/* rtl/fence_deferred_slot_allocator_macros.svh */
// Assertion macros shared by the slot allocator RTL
`ifndef FENCE_DEFERRED_SLOT_ALLOCATOR_MACROS_SVH
`define FENCE_DEFERRED_SLOT_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked at every rising edge outside reset
`define FDSA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fdsa same-cycle check failed");
// next-cycle implication
`define FDSA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fdsa next-cycle check failed");
`else
`define FDSA_ASSERT_SAME(lbl, ante, cons)
`define FDSA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/fdsa_pkg.sv */
// Shared types, codes and widths of the fence deferred slot allocator
package fdsa_pkg;

    localparam int DEFAULT_SLOT_COUNT = 256;

    localparam int SLOT_W   = 16;
    localparam int FENCE_W  = 64;
    localparam int ADDR_W   = 64;
    localparam int STRIDE_W = 32;
    localparam int PROD_W   = SLOT_W + STRIDE_W;
    localparam int RCNT_W   = 16;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_STRIDE  = 1'b1;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_RECLAIM = 2'd2,
        OP_UNUSED  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_BAD_SLOT  = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        op_t                operation;
        logic [SLOT_W-1:0]  slot;
        logic [FENCE_W-1:0] fence;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot_out;
        logic [ADDR_W-1:0] slot_address;
        logic [RCNT_W-1:0] reclaimed_count;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic start;    // request accepted this cycle
        logic capture;  // free stack read data is valid
        logic walk;     // one pending list entry is processed
        logic mul;      // form slot times stride
        logic load;     // load the response register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  req_op;
        logic free_empty;
        logic pend_empty;
        logic walk_last;
    } sts_t;

endpackage

/* rtl/fdsa_ctrl.sv */
// Controller state machine of the slot allocator
`include "fence_deferred_slot_allocator_macros.svh"

module fdsa_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  fdsa_pkg::sts_t sts,
    output fdsa_pkg::cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ARD  = 5'b00010,
        S_WALK = 5'b00100,
        S_MUL  = 5'b01000,
        S_ADD  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_busy;

    // handshake and commands
    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign out_busy    = out_valid_reg && !out_ready;
    assign out_valid   = out_valid_reg;

    assign cmd.start   = accept;
    assign cmd.capture = (state_reg == S_ARD);
    assign cmd.walk    = (state_reg == S_WALK);
    assign cmd.mul     = (state_reg == S_MUL);
    assign cmd.load    = (state_reg == S_ADD) && !out_busy;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (sts.req_op)
                        fdsa_pkg::OP_ALLOC:
                            state_next = sts.free_empty ? S_MUL : S_ARD;
                        fdsa_pkg::OP_RECLAIM:
                            state_next = sts.pend_empty ? S_MUL : S_WALK;
                        default:
                            state_next = S_MUL;
                    endcase
                end
            end
            S_ARD:  state_next = S_MUL;
            S_WALK:
            begin
                if (sts.walk_last)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:  state_next = S_ADD;
            S_ADD:
            begin
                if (!out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // response valid: set on load, cleared when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `FDSA_ASSERT_NEXT(a_one_at_a_time, accept, !in_ready)
    `FDSA_ASSERT_NEXT(a_load_shows, (state_reg == S_ADD) && !out_busy, out_valid_reg)
    `FDSA_ASSERT_NEXT(a_walk_ends, (state_reg == S_WALK) && sts.walk_last, state_reg == S_MUL)

endmodule

/* rtl/fdsa_dp.sv */
// Datapath of the slot allocator: free stack, pending list, counters, address unit
`include "fence_deferred_slot_allocator_macros.svh"

module fdsa_dp
#(
    parameter int SLOT_COUNT = fdsa_pkg::DEFAULT_SLOT_COUNT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  fdsa_pkg::cmd_t                   cmd,
    output fdsa_pkg::sts_t                   sts,
    input  fdsa_pkg::req_t                   in_data,
    output fdsa_pkg::rsp_t                   out_data,
    input  logic                             cfg_we,
    input  logic [fdsa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fdsa_pkg::CFG_W-1:0]       cfg_data
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOT_COUNT);

    // memories
    logic [fdsa_pkg::SLOT_W-1:0]  free_stack_mem [SLOT_COUNT];
    logic [fdsa_pkg::SLOT_W-1:0]  pend_slot_mem  [SLOT_COUNT];
    logic [fdsa_pkg::FENCE_W-1:0] pend_fence_mem [SLOT_COUNT];

    // control registers
    logic [fdsa_pkg::ADDR_W-1:0]   base_reg, base_next;
    logic [fdsa_pkg::STRIDE_W-1:0] stride_reg, stride_next;
    logic [CNT_W-1:0]              fc_reg, fc_next;
    logic [CNT_W-1:0]              low_mark_reg, low_mark_next;
    logic [CNT_W-1:0]              pc_reg, pc_next;

    // payload registers
    logic [fdsa_pkg::FENCE_W-1:0] fence_reg, fence_next;
    logic [fdsa_pkg::SLOT_W-1:0]  slot_res_reg, slot_res_next;
    fdsa_pkg::status_t            status_reg, status_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [CNT_W-1:0]             rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]             left_reg, left_next;
    logic [CNT_W-1:0]             w_reg, w_next;
    logic                         orig_reg, orig_next;
    logic [fdsa_pkg::SLOT_W-1:0]  orig_val_reg, orig_val_next;
    logic [fdsa_pkg::PROD_W-1:0]  prod_reg, prod_next;
    fdsa_pkg::rsp_t               rsp_reg, rsp_next;

    // memory read data
    logic [fdsa_pkg::SLOT_W-1:0]  fs_rd_reg;
    logic [fdsa_pkg::SLOT_W-1:0]  ps_rd_reg;
    logic [fdsa_pkg::FENCE_W-1:0] pf_rd_reg;

    // memory ports
    logic                         fs_we, fs_re;
    logic [IDX_W-1:0]             fs_waddr, fs_raddr;
    logic [fdsa_pkg::SLOT_W-1:0]  fs_wdata;
    logic                         pm_we, pm_re;
    logic [IDX_W-1:0]             pm_waddr, pm_raddr;
    logic [fdsa_pkg::SLOT_W-1:0]  pm_wslot;
    logic [fdsa_pkg::FENCE_W-1:0] pm_wfence;

    logic [CNT_W-1:0] fc_dec;
    logic             retire;

    assign fc_dec = fc_reg - 1'b1;
    assign retire = (pf_rd_reg <= fence_reg);

    // status to controller
    assign sts.req_op     = in_data.operation;
    assign sts.free_empty = (fc_reg == '0);
    assign sts.pend_empty = (pc_reg == '0);
    assign sts.walk_last  = (left_reg == CNT_W'(1));

    assign out_data = rsp_reg;

    // configuration writes
    always_comb
    begin
        base_next   = base_reg;
        stride_next = stride_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                fdsa_pkg::REG_BASE_ADDRESS: base_next   = cfg_data;
                fdsa_pkg::REG_SLOT_STRIDE:  stride_next = cfg_data[fdsa_pkg::STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    // operation datapath
    always_comb
    begin
        fc_next       = fc_reg;
        low_mark_next = low_mark_reg;
        pc_next       = pc_reg;
        fence_next    = fence_reg;
        slot_res_next = slot_res_reg;
        status_next   = status_reg;
        cnt_next      = cnt_reg;
        rd_idx_next   = rd_idx_reg;
        left_next     = left_reg;
        w_next        = w_reg;
        orig_next     = orig_reg;
        orig_val_next = orig_val_reg;
        prod_next     = prod_reg;
        rsp_next      = rsp_reg;
        fs_we         = 1'b0;
        fs_re         = 1'b0;
        fs_waddr      = fc_reg[IDX_W-1:0];
        fs_raddr      = fc_dec[IDX_W-1:0];
        fs_wdata      = ps_rd_reg;
        pm_we         = 1'b0;
        pm_re         = 1'b0;
        pm_waddr      = pc_reg[IDX_W-1:0];
        pm_raddr      = rd_idx_reg[IDX_W-1:0];
        pm_wslot      = in_data.slot;
        pm_wfence     = in_data.fence;

        // request accepted
        if (cmd.start)
        begin
            fence_next    = in_data.fence;
            status_next   = fdsa_pkg::ST_OK;
            slot_res_next = '0;
            cnt_next      = '0;
            case (in_data.operation)
                fdsa_pkg::OP_ALLOC:
                begin
                    if (fc_reg == '0)
                    begin
                        status_next = fdsa_pkg::ST_EXHAUSTED;
                    end
                    else
                    begin
                        // entries below the low mark were never written and stand for their reset contents
                        fs_re         = 1'b1;
                        fc_next       = fc_dec;
                        orig_next     = (fc_dec < low_mark_reg);
                        orig_val_next = fdsa_pkg::SLOT_W'(FULL_CNT - fc_reg);
                        if (fc_dec < low_mark_reg)
                        begin
                            low_mark_next = fc_dec;
                        end
                    end
                end
                fdsa_pkg::OP_RELEASE:
                begin
                    slot_res_next = in_data.slot;
                    if ({1'b0, in_data.slot} >= (fdsa_pkg::SLOT_W + 1)'(SLOT_COUNT))
                    begin
                        status_next = fdsa_pkg::ST_BAD_SLOT;
                    end
                    else if (pc_reg == FULL_CNT)
                    begin
                        status_next = fdsa_pkg::ST_FULL;
                    end
                    else
                    begin
                        pm_we   = 1'b1;
                        pc_next = pc_reg + 1'b1;
                    end
                end
                fdsa_pkg::OP_RECLAIM:
                begin
                    if (pc_reg != '0)
                    begin
                        pm_re       = 1'b1;
                        pm_raddr    = '0;
                        rd_idx_next = CNT_W'(1);
                        left_next   = pc_reg;
                        w_next      = '0;
                    end
                end
                default: ;
            endcase
        end

        // allocated slot arrives from the free stack, or from the low-mark value
        if (cmd.capture)
        begin
            slot_res_next = orig_reg ? orig_val_reg : fs_rd_reg;
        end

        // one pending entry: retire it or compact it, and fetch the next
        if (cmd.walk)
        begin
            if (retire && (fc_reg < FULL_CNT))
            begin
                fs_we    = 1'b1;
                fs_wdata = ps_rd_reg;
                fc_next  = fc_reg + 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            else
            begin
                if (retire)
                begin
                    status_next = fdsa_pkg::ST_FULL;
                end
                pm_we     = 1'b1;
                pm_waddr  = w_reg[IDX_W-1:0];
                pm_wslot  = ps_rd_reg;
                pm_wfence = pf_rd_reg;
                w_next    = w_reg + 1'b1;
            end
            pm_re       = 1'b1;
            rd_idx_next = rd_idx_reg + 1'b1;
            left_next   = left_reg - 1'b1;
            if (left_reg == CNT_W'(1))
            begin
                pc_next = w_next;
            end
        end

        // address: multiply, then add
        if (cmd.mul)
        begin
            prod_next = slot_res_reg * stride_reg;
        end

        if (cmd.load)
        begin
            rsp_next.status          = status_reg;
            rsp_next.slot_out        = slot_res_reg;
            rsp_next.slot_address    = base_reg + fdsa_pkg::ADDR_W'(prod_reg);
            rsp_next.reclaimed_count = fdsa_pkg::RCNT_W'(cnt_reg);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= '0;
            stride_reg   <= '0;
            fc_reg       <= FULL_CNT;
            low_mark_reg <= FULL_CNT;
            pc_reg       <= '0;
        end
        else
        begin
            base_reg     <= base_next;
            stride_reg   <= stride_next;
            fc_reg       <= fc_next;
            low_mark_reg <= low_mark_next;
            pc_reg       <= pc_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        fence_reg    <= fence_next;
        slot_res_reg <= slot_res_next;
        status_reg   <= status_next;
        cnt_reg      <= cnt_next;
        rd_idx_reg   <= rd_idx_next;
        left_reg     <= left_next;
        w_reg        <= w_next;
        orig_reg     <= orig_next;
        orig_val_reg <= orig_val_next;
        prod_reg     <= prod_next;
        rsp_reg      <= rsp_next;
    end

    // free stack memory
    always_ff @(posedge clk)
    begin
        if (fs_we)
        begin
            free_stack_mem[fs_waddr] <= fs_wdata;
        end
        if (fs_re)
        begin
            fs_rd_reg <= free_stack_mem[fs_raddr];
        end
    end

    // pending list memory
    always_ff @(posedge clk)
    begin
        if (pm_we)
        begin
            pend_slot_mem[pm_waddr]  <= pm_wslot;
            pend_fence_mem[pm_waddr] <= pm_wfence;
        end
        if (pm_re)
        begin
            ps_rd_reg <= pend_slot_mem[pm_raddr];
            pf_rd_reg <= pend_fence_mem[pm_raddr];
        end
    end

    `FDSA_ASSERT_SAME(a_counts_bounded, 1'b1, (fc_reg <= FULL_CNT) && (pc_reg <= FULL_CNT))
    `FDSA_ASSERT_NEXT(a_alloc_pops, cmd.start && (in_data.operation == fdsa_pkg::OP_ALLOC) && (fc_reg != '0), (fc_reg + 1'b1) == $past(fc_reg))
    `FDSA_ASSERT_SAME(a_compact_behind, cmd.walk, w_reg < rd_idx_reg)

endmodule

/* rtl/fence_deferred_slot_allocator.sv */
// Top level of the fence deferred slot allocator
//
//   port group  direction  handshake              contents
//   in_*        request    in_valid / in_ready    operation, slot, fence
//   out_*       response   out_valid / out_ready  status, slot_out, slot_address, reclaimed_count
//   cfg_*       config     cfg_we                 base address (0), slot stride (1)
//
// One request at a time. Allocate: free stack read, slot capture, multiply, add; release
// and the unused code: multiply, add; reclaim: a walk of its N pending entries, one a cycle
// through the pending list memory port, then multiply, add. An empty free stack or list skips
// to multiply. No clearing pass after reset: a low-water mark on the free stack stands in
// for the reset contents, so a request can be taken as soon as reset is released.
// A held response stalls only the final stage; the next request waits for it to load.
module fence_deferred_slot_allocator
#(
    parameter int SLOT_COUNT = fdsa_pkg::DEFAULT_SLOT_COUNT
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  fdsa_pkg::req_t                 in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output fdsa_pkg::rsp_t                 out_data,
    input  logic                           cfg_we,
    input  logic [fdsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fdsa_pkg::CFG_W-1:0]     cfg_data
);

    fdsa_pkg::cmd_t cmd;
    fdsa_pkg::sts_t sts;

    // sequencing
    fdsa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // storage and arithmetic
    fdsa_dp
    #(
        .SLOT_COUNT (SLOT_COUNT)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
